// ===== rtl/wpto_pkg.sv =====
`default_nettype none

package wpto_pkg;

    localparam int MAX_PATTERNS  = 1024;
    localparam int PAT_AW        = $clog2(MAX_PATTERNS);
    localparam int CNT_W         = PAT_AW + 1;
    localparam int MAX_EDGES     = 8192;
    localparam int EDGE_AW       = $clog2(MAX_EDGES);
    localparam int LINK_W        = EDGE_AW + 1;
    localparam int DEG_W         = 14;
    localparam int MAX_KEY_CHARS = 4;
    localparam int KEY_W         = 32;

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);
    localparam logic [7:0]        WILDCARD   = 8'd95;

    typedef enum logic [1:0] {
        MD_LOAD  = 2'd0,
        MD_QUERY = 2'd1,
        MD_SORT  = 2'd2,
        MD_READ  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RS_OK       = 3'd0,
        RS_QFAIL    = 3'd1,
        RS_SORT_YES = 3'd2,
        RS_SORT_NO  = 3'd3,
        RS_FULL     = 3'd4,
        RS_BAD_IDX  = 3'd5
    } rstat_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_QUERY, S_Q_REQ, S_Q_CHK, S_Q_RD, S_Q_TEST,
        S_Q_EDGE, S_SORT, S_S_IRD, S_S_IWR, S_S_POP, S_S_CUR, S_S_HEAD,
        S_S_ECHK, S_S_TGT, S_S_DEC, S_S_DONE, S_READ, S_R_WAIT, S_RESP
    } state_t;

    typedef struct packed {
        state_t op;
        logic   accept;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic fail;
        logic idx_bad;
        logic pat_match;
        logic j_end;
        logic scan_hit;
        logic edge_full;
        logic queue_empty;
        logic link_empty;
        logic read_bad;
    } sts_t;

    function automatic logic key_match(logic [KEY_W-1:0] pat, logic [KEY_W-1:0] key,
                                       logic [2:0] klen);
        logic [2:0] len;
        logic       ok;
        len = (klen == 3'd0) ? 3'd1 : ((klen > 3'(MAX_KEY_CHARS)) ? 3'(MAX_KEY_CHARS) : klen);
        ok  = 1'b1;
        for (int i = 0; i < MAX_KEY_CHARS; i++) begin
            if (3'(i) < len && pat[8*i +: 8] != WILDCARD && pat[8*i +: 8] != key[8*i +: 8])
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wildcard_pattern_topo_order.sv =====
`default_nettype none

// channel   | direction | tdata                          | tuser
// s_        | in        | [31:0] key, [42:32] target_idx | [1:0] mode
// m_        | out       | [10:0] value                   | [2:0] status
// cfg_      | in        | [2:0] key_length               | -
//
// load, order read, query (patterns scanned, edges added) and sort (edge lists walked)
// all run through memories with one registered read port and one write port each
// after reset a clearing pass over all 1024 in-degree and list-head entries runs, input held off
// one transaction at a time; the result holds on m_ until taken

module wildcard_pattern_topo_order
    import wpto_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // key, target_index
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // value
    output logic [2:0]       m_tuser,   // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // key_length
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    wpto_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpto_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("result pending while input open");

    assert property (@(posedge aclk) disable iff (!aresetn) s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken before result");

    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> m_tuser <= 3'd5)
        else $error("status code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

endmodule

`default_nettype wire

// ===== rtl/wpto_ctrl.sv =====
`default_nettype none

module wpto_ctrl
    import wpto_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic [1:0] s_tuser,
    input  wire logic       m_tready,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (mode_t'(s_tuser))
                        MD_LOAD:  state_next = S_LOAD;
                        MD_QUERY: state_next = S_QUERY;
                        MD_SORT:  state_next = S_SORT;
                        MD_READ:  state_next = S_READ;
                    endcase
                end
            end
            S_LOAD:   state_next = S_RESP;
            S_QUERY:  state_next = (sts.fail || sts.idx_bad) ? S_RESP : S_Q_REQ;
            S_Q_REQ:  state_next = S_Q_CHK;
            S_Q_CHK:  state_next = sts.pat_match ? S_Q_RD : S_RESP;
            S_Q_RD:   state_next = sts.j_end ? S_RESP : S_Q_TEST;
            S_Q_TEST: begin
                if (sts.scan_hit) state_next = sts.edge_full ? S_RESP : S_Q_EDGE;
                else              state_next = S_Q_RD;
            end
            S_Q_EDGE: state_next = S_Q_RD;
            S_SORT:   state_next = sts.fail ? S_RESP : S_S_IRD;
            S_S_IRD:  state_next = sts.j_end ? S_S_POP : S_S_IWR;
            S_S_IWR:  state_next = S_S_IRD;
            S_S_POP:  state_next = sts.queue_empty ? S_S_DONE : S_S_CUR;
            S_S_CUR:  state_next = S_S_HEAD;
            S_S_HEAD: state_next = S_S_ECHK;
            S_S_ECHK: state_next = sts.link_empty ? S_S_POP : S_S_TGT;
            S_S_TGT:  state_next = S_S_DEC;
            S_S_DEC:  state_next = S_S_ECHK;
            S_S_DONE: state_next = S_RESP;
            S_READ:   state_next = sts.read_bad ? S_RESP : S_R_WAIT;
            S_R_WAIT: state_next = S_RESP;
            S_RESP:   if (m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == S_IDLE);
        m_tvalid   = (state_reg == S_RESP);
        cmd.op     = state_reg;
        cmd.accept = (state_reg == S_IDLE) && s_tvalid;
    end

endmodule

`default_nettype wire

// ===== rtl/wpto_dp.sv =====
`default_nettype none

module wpto_dp
    import wpto_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic [47:0] s_tdata,
    input  wire logic        cfg_valid,
    input  wire logic [7:0]  cfg_data,
    output logic [15:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    // control registers
    logic [2:0]        key_length_reg;
    logic [CNT_W-1:0]  pat_count_reg, pat_count_next;
    logic [LINK_W-1:0] edge_count_reg, edge_count_next;
    logic [CNT_W-1:0]  order_count_reg, order_count_next;
    logic              fail_reg, fail_next;
    logic [PAT_AW-1:0] clr_reg, clr_next;

    // working registers
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [PAT_AW-1:0] req_reg, req_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LINK_W-1:0] e_reg, e_next;
    logic [LINK_W-1:0] enext_reg, enext_next;
    logic [PAT_AW-1:0] t_reg, t_next;
    logic [2:0]        status_reg, status_next;
    logic [CNT_W-1:0]  value_reg, value_next;

    // memories
    logic [KEY_W-1:0]  pat_mem   [MAX_PATTERNS];
    logic [DEG_W-1:0]  indeg_mem [MAX_PATTERNS];
    logic [LINK_W-1:0] head_mem  [MAX_PATTERNS];
    logic [LINK_W-1:0] tail_mem  [MAX_PATTERNS];
    logic [PAT_AW-1:0] etgt_mem  [MAX_EDGES];
    logic [LINK_W-1:0] enext_mem [MAX_EDGES];
    logic [PAT_AW-1:0] order_mem [MAX_PATTERNS];
    logic [DEG_W-1:0]  wdeg_mem  [MAX_PATTERNS];

    logic              pat_we, indeg_we, head_we, tail_we, etgt_we, enext_we;
    logic              order_we, wdeg_we;
    logic [PAT_AW-1:0] pat_wa, pat_ra, indeg_wa, indeg_ra, head_wa, head_ra;
    logic [PAT_AW-1:0] tail_wa, tail_ra, order_wa, order_ra, wdeg_wa, wdeg_ra;
    logic [EDGE_AW-1:0] etgt_wa, enext_wa, edge_ra;
    logic [KEY_W-1:0]  pat_wd, pat_rd;
    logic [DEG_W-1:0]  indeg_wd, indeg_rd, wdeg_wd, wdeg_rd;
    logic [LINK_W-1:0] head_wd, head_rd, tail_wd, tail_rd, enext_wd, enext_rd;
    logic [PAT_AW-1:0] etgt_wd, etgt_rd, order_wd, order_rd;

    logic [PAT_AW-1:0] req_idx;
    logic              pat_full;

    always_ff @(posedge aclk) begin
        if (pat_we) pat_mem[pat_wa] <= pat_wd;
        pat_rd <= pat_mem[pat_ra];
    end
    always_ff @(posedge aclk) begin
        if (indeg_we) indeg_mem[indeg_wa] <= indeg_wd;
        indeg_rd <= indeg_mem[indeg_ra];
    end
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end
    always_ff @(posedge aclk) begin
        if (tail_we) tail_mem[tail_wa] <= tail_wd;
        tail_rd <= tail_mem[tail_ra];
    end
    always_ff @(posedge aclk) begin
        if (etgt_we) etgt_mem[etgt_wa] <= etgt_wd;
        etgt_rd <= etgt_mem[edge_ra];
    end
    always_ff @(posedge aclk) begin
        if (enext_we) enext_mem[enext_wa] <= enext_wd;
        enext_rd <= enext_mem[edge_ra];
    end
    always_ff @(posedge aclk) begin
        if (order_we) order_mem[order_wa] <= order_wd;
        order_rd <= order_mem[order_ra];
    end
    always_ff @(posedge aclk) begin
        if (wdeg_we) wdeg_mem[wdeg_wa] <= wdeg_wd;
        wdeg_rd <= wdeg_mem[wdeg_ra];
    end

    assign req_idx  = PAT_AW'(idx_reg - CNT_W'(1));
    assign pat_full = (pat_count_reg == CNT_W'(MAX_PATTERNS));

    always_comb begin
        sts.clr_last    = (clr_reg == {PAT_AW{1'b1}});
        sts.fail        = fail_reg;
        sts.idx_bad     = (idx_reg == '0) || (idx_reg > pat_count_reg);
        sts.pat_match   = key_match(pat_rd, key_reg, key_length_reg);
        sts.j_end       = (j_reg >= pat_count_reg);
        sts.scan_hit    = sts.pat_match && (j_reg[PAT_AW-1:0] != req_reg);
        sts.edge_full   = (edge_count_reg == LINK_W'(MAX_EDGES));
        sts.queue_empty = (front_reg >= cnt_reg);
        sts.link_empty  = (e_reg == EMPTY_LINK);
        sts.read_bad    = (idx_reg >= order_count_reg);
    end

    always_comb begin
        pat_count_next   = pat_count_reg;
        edge_count_next  = edge_count_reg;
        order_count_next = order_count_reg;
        fail_next        = fail_reg;
        clr_next         = clr_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        req_next         = req_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        j_next           = j_reg;
        front_next       = front_reg;
        cnt_next         = cnt_reg;
        e_next           = e_reg;
        enext_next       = enext_reg;
        t_next           = t_reg;
        status_next      = status_reg;
        value_next       = value_reg;

        pat_we   = 1'b0; pat_wa   = '0; pat_wd   = key_reg; pat_ra   = '0;
        indeg_we = 1'b0; indeg_wa = '0; indeg_wd = '0;      indeg_ra = '0;
        head_we  = 1'b0; head_wa  = '0; head_wd  = '0;      head_ra  = '0;
        tail_we  = 1'b0; tail_wa  = '0; tail_wd  = '0;      tail_ra  = '0;
        etgt_we  = 1'b0; etgt_wa  = '0; etgt_wd  = '0;
        enext_we = 1'b0; enext_wa = '0; enext_wd = '0;      edge_ra  = '0;
        order_we = 1'b0; order_wa = '0; order_wd = '0;      order_ra = '0;
        wdeg_we  = 1'b0; wdeg_wa  = '0; wdeg_wd  = '0;      wdeg_ra  = '0;

        unique case (cmd.op)
            S_CLEAR: begin
                indeg_we = 1'b1;
                indeg_wa = clr_reg;
                head_we  = 1'b1;
                head_wa  = clr_reg;
                head_wd  = EMPTY_LINK;
                clr_next = clr_reg + PAT_AW'(1);
            end
            S_IDLE: begin
                if (cmd.accept) begin
                    key_next    = s_tdata[31:0];
                    idx_next    = s_tdata[42:32];
                    status_next = RS_OK;
                    value_next  = '0;
                end
            end
            S_LOAD: begin
                if (pat_full) begin
                    status_next = RS_FULL;
                end else begin
                    pat_we         = 1'b1;
                    pat_wa         = pat_count_reg[PAT_AW-1:0];
                    pat_count_next = pat_count_reg + CNT_W'(1);
                    value_next     = pat_count_reg + CNT_W'(1);
                end
            end
            S_QUERY: begin
                if (fail_reg)        status_next = RS_QFAIL;
                else if (sts.idx_bad) status_next = RS_BAD_IDX;
            end
            S_Q_REQ: begin
                pat_ra   = req_idx;
                head_ra  = req_idx;
                tail_ra  = req_idx;
                req_next = req_idx;
            end
            S_Q_CHK: begin
                if (!sts.pat_match) begin
                    fail_next   = 1'b1;
                    status_next = RS_QFAIL;
                end else begin
                    head_next = head_rd;
                    tail_next = tail_rd;
                    j_next    = '0;
                end
            end
            S_Q_RD: begin
                pat_ra = j_reg[PAT_AW-1:0];
            end
            S_Q_TEST: begin
                indeg_ra = j_reg[PAT_AW-1:0];
                if (sts.scan_hit) begin
                    if (sts.edge_full) begin
                        status_next = RS_FULL;
                    end else begin
                        etgt_we = 1'b1;
                        etgt_wa = edge_count_reg[EDGE_AW-1:0];
                        etgt_wd = j_reg[PAT_AW-1:0];
                        if (head_reg == EMPTY_LINK) begin
                            head_we   = 1'b1;
                            head_wa   = req_reg;
                            head_wd   = edge_count_reg;
                            head_next = edge_count_reg;
                        end else begin
                            enext_we = 1'b1;
                            enext_wa = tail_reg[EDGE_AW-1:0];
                            enext_wd = edge_count_reg;
                        end
                    end
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            S_Q_EDGE: begin
                indeg_we        = 1'b1;
                indeg_wa        = j_reg[PAT_AW-1:0];
                indeg_wd        = indeg_rd + DEG_W'(1);
                enext_we        = 1'b1;
                enext_wa        = edge_count_reg[EDGE_AW-1:0];
                enext_wd        = EMPTY_LINK;
                tail_we         = 1'b1;
                tail_wa         = req_reg;
                tail_wd         = edge_count_reg;
                tail_next       = edge_count_reg;
                edge_count_next = edge_count_reg + LINK_W'(1);
                j_next          = j_reg + CNT_W'(1);
            end
            S_SORT: begin
                if (fail_reg) begin
                    order_count_next = '0;
                    status_next      = RS_SORT_NO;
                end else begin
                    j_next     = '0;
                    cnt_next   = '0;
                    front_next = '0;
                end
            end
            S_S_IRD: begin
                indeg_ra = j_reg[PAT_AW-1:0];
            end
            S_S_IWR: begin
                wdeg_we = 1'b1;
                wdeg_wa = j_reg[PAT_AW-1:0];
                wdeg_wd = indeg_rd;
                if (indeg_rd == '0) begin
                    order_we = 1'b1;
                    order_wa = cnt_reg[PAT_AW-1:0];
                    order_wd = j_reg[PAT_AW-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                j_next = j_reg + CNT_W'(1);
            end
            S_S_POP: begin
                order_ra = front_reg[PAT_AW-1:0];
                if (!sts.queue_empty) front_next = front_reg + CNT_W'(1);
            end
            S_S_CUR: begin
                head_ra = order_rd;
            end
            S_S_HEAD: begin
                e_next = head_rd;
            end
            S_S_ECHK: begin
                edge_ra = e_reg[EDGE_AW-1:0];
            end
            S_S_TGT: begin
                t_next     = etgt_rd;
                enext_next = enext_rd;
                wdeg_ra    = etgt_rd;
            end
            S_S_DEC: begin
                if (wdeg_rd != '0) begin
                    wdeg_we = 1'b1;
                    wdeg_wa = t_reg;
                    wdeg_wd = wdeg_rd - DEG_W'(1);
                    if (wdeg_rd == DEG_W'(1)) begin
                        order_we = 1'b1;
                        order_wa = cnt_reg[PAT_AW-1:0];
                        order_wd = t_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                e_next = enext_reg;
            end
            S_S_DONE: begin
                order_count_next = cnt_reg;
                value_next       = cnt_reg;
                status_next      = (cnt_reg == pat_count_reg) ? RS_SORT_YES : RS_SORT_NO;
            end
            S_READ: begin
                order_ra = idx_reg[PAT_AW-1:0];
                if (sts.read_bad) status_next = RS_BAD_IDX;
            end
            S_R_WAIT: begin
                value_next = {1'b0, order_rd} + CNT_W'(1);
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg  <= 3'd4;
            pat_count_reg   <= '0;
            edge_count_reg  <= '0;
            order_count_reg <= '0;
            fail_reg        <= 1'b0;
            clr_reg         <= '0;
        end else begin
            if (cfg_valid) key_length_reg <= cfg_data[2:0];
            pat_count_reg   <= pat_count_next;
            edge_count_reg  <= edge_count_next;
            order_count_reg <= order_count_next;
            fail_reg        <= fail_next;
            clr_reg         <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        req_reg    <= req_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        j_reg      <= j_next;
        front_reg  <= front_next;
        cnt_reg    <= cnt_next;
        e_reg      <= e_next;
        enext_reg  <= enext_next;
        t_reg      <= t_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign m_tuser = status_reg;
    assign m_tdata = {5'd0, value_reg};

endmodule

`default_nettype wire
